// File: hw/rtl/sis_pkg.sv
// ----------------------------------------------------------------------------
// sis_pkg
// Shared types and constants of the sorted integer set: payload structs,
// operation codes and the command/status bundles between controller and
// datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package sis_pkg;

  // Default store capacity in entries.
  localparam int unsigned CAPACITY_DEF = 64;

  // Operation codes carried in the mode field. Any other code acts as a query.
  localparam logic [1:0] MODE_ADD    = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_QUERY  = 2'd2;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic       was_present;
    logic       refused_full;
    logic [6:0] count;
  } out_item_t;

  // Controller to datapath.
  typedef struct packed {
    logic start;        // latch the item, open the search window
    logic srch_rd;      // read the window midpoint
    logic srch_upd;     // narrow the window on the read entry
    logic chk_rd;       // read the entry at the found position
    logic chk_latch;    // latch the membership flag
    logic set_refused;  // flag an add into a full store
    logic up_init;      // point the shift index at the top entry
    logic up_rd;        // read entry at the shift index
    logic up_wr;        // move it one place up, step the index down
    logic put;          // store the new value, bump the count
    logic dn_init;      // point the shift index at the found position
    logic dn_rd;        // read entry above the shift index
    logic dn_wr;        // move it one place down, step the index up
    logic cnt_dec;      // drop the count by one
    logic result_load;  // load the result register
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic srch_done;    // search window is empty
    logic is_add;
    logic is_remove;
    logic present_now;  // found entry equals the value (valid in the check step)
    logic full;
    logic pos_at_end;   // found position is the first free slot
    logic dn_start_more;// entries sit above the found position
    logic up_last;      // shift index has reached the found position
    logic dn_more;      // another entry remains to move down
  } stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/sis_ctrl.sv
// ----------------------------------------------------------------------------
// sis_ctrl
// Sequencer of the sorted integer set: steps the binary search, the
// membership check, the shift of entries and the hand-off of the result.
// ----------------------------------------------------------------------------
`default_nettype none

module sis_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  input  wire sis_pkg::stat_t stat_i,
  output sis_pkg::cmd_t       cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH,
    S_CMP,
    S_CHECK,
    S_UP_RD,
    S_UP_WR,
    S_PUT,
    S_DN_RD,
    S_DN_WR,
    S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign slot_free   = !out_valid_q || out_ready_i;

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = S_SRCH;
        end
      end
      S_SRCH: begin
        if (stat_i.srch_done) begin
          cmd_o.chk_rd = 1'b1;
          state_d      = S_CHECK;
        end else begin
          cmd_o.srch_rd = 1'b1;
          state_d       = S_CMP;
        end
      end
      S_CMP: begin
        cmd_o.srch_upd = 1'b1;
        state_d        = S_SRCH;
      end
      S_CHECK: begin
        cmd_o.chk_latch = 1'b1;
        state_d         = S_DONE;
        if (stat_i.is_add && !stat_i.present_now) begin
          if (stat_i.full) begin
            cmd_o.set_refused = 1'b1;
          end else if (stat_i.pos_at_end) begin
            state_d = S_PUT;
          end else begin
            cmd_o.up_init = 1'b1;
            state_d       = S_UP_RD;
          end
        end else if (stat_i.is_remove && stat_i.present_now) begin
          if (stat_i.dn_start_more) begin
            cmd_o.dn_init = 1'b1;
            state_d       = S_DN_RD;
          end else begin
            cmd_o.cnt_dec = 1'b1;
          end
        end
      end
      S_UP_RD: begin
        cmd_o.up_rd = 1'b1;
        state_d     = S_UP_WR;
      end
      S_UP_WR: begin
        cmd_o.up_wr = 1'b1;
        state_d     = stat_i.up_last ? S_PUT : S_UP_RD;
      end
      S_PUT: begin
        cmd_o.put = 1'b1;
        state_d   = S_DONE;
      end
      S_DN_RD: begin
        cmd_o.dn_rd = 1'b1;
        state_d     = S_DN_WR;
      end
      S_DN_WR: begin
        cmd_o.dn_wr = 1'b1;
        if (stat_i.dn_more) begin
          state_d = S_DN_RD;
        end else begin
          cmd_o.cnt_dec = 1'b1;
          state_d       = S_DONE;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          cmd_o.result_load = 1'b1;
          out_valid_d       = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/sis_dpath.sv
// ----------------------------------------------------------------------------
// sis_dpath
// Datapath of the sorted integer set: entry store, search window, shift
// index, entry count and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sis_dpath #(
  parameter int unsigned CAPACITY = sis_pkg::CAPACITY_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire sis_pkg::in_item_t  in_item_i,
  input  wire sis_pkg::cmd_t      cmd_i,
  output sis_pkg::stat_t          stat_o,
  output sis_pkg::out_item_t      out_item_o
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic [31:0]        mem [CAPACITY];
  logic [31:0]        rdata_q;

  sis_pkg::in_item_t  item_q;
  sis_pkg::out_item_t result_q;
  logic [CW-1:0]      lo_q, hi_q, idx_q, count_q;
  logic               present_q, refused_q;

  logic [CW-1:0]      mid;
  logic [CW-1:0]      idx_p1;
  logic [CW:0]        lo_p1, idx_p2;
  logic [CW+6:0]      count_ext;
  logic               rd_en, wr_en;
  logic [CW-1:0]      rd_addr, wr_addr;
  logic [31:0]        wr_data;
  logic               entry_less;

  assign mid        = lo_q + ((hi_q - lo_q) >> 1);
  assign idx_p1     = idx_q + {{(CW-1){1'b0}}, 1'b1};
  assign lo_p1      = {1'b0, lo_q} + {{CW{1'b0}}, 1'b1};
  assign idx_p2     = {1'b0, idx_q} + {{(CW-1){1'b0}}, 2'd2};
  assign entry_less = $signed(rdata_q) < item_q.value;
  assign count_ext  = {7'd0, count_q};

  // Status back to the sequencer.
  always_comb begin
    stat_o.srch_done     = (lo_q >= hi_q);
    stat_o.is_add        = (item_q.mode == sis_pkg::MODE_ADD);
    stat_o.is_remove     = (item_q.mode == sis_pkg::MODE_REMOVE);
    stat_o.present_now   = (lo_q < count_q) && (rdata_q == item_q.value);
    stat_o.full          = (count_q >= CW'(CAPACITY));
    stat_o.pos_at_end    = (lo_q == count_q);
    stat_o.dn_start_more = (lo_p1 < {1'b0, count_q});
    stat_o.up_last       = (idx_q == lo_q);
    stat_o.dn_more       = (idx_p2 < {1'b0, count_q});
  end

  // Store port selection.
  always_comb begin
    rd_en   = cmd_i.srch_rd || cmd_i.chk_rd || cmd_i.up_rd || cmd_i.dn_rd;
    rd_addr = idx_q;
    if (cmd_i.srch_rd) begin
      rd_addr = mid;
    end else if (cmd_i.chk_rd) begin
      rd_addr = lo_q;
    end else if (cmd_i.dn_rd) begin
      rd_addr = idx_p1;
    end
    wr_en   = cmd_i.up_wr || cmd_i.put || cmd_i.dn_wr;
    wr_addr = idx_q;
    wr_data = rdata_q;
    if (cmd_i.up_wr) begin
      wr_addr = idx_p1;
    end else if (cmd_i.put) begin
      wr_addr = lo_q;
      wr_data = item_q.value;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr[AW-1:0]] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr[AW-1:0]];
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      item_q <= in_item_i;
    end
    if (cmd_i.chk_latch) begin
      present_q <= stat_o.present_now;
    end
    if (cmd_i.result_load) begin
      result_q.was_present  <= present_q;
      result_q.refused_full <= refused_q;
      result_q.count        <= count_ext[6:0];
    end
    if (cmd_i.up_init) begin
      idx_q <= count_q - {{(CW-1){1'b0}}, 1'b1};
    end else if (cmd_i.dn_init) begin
      idx_q <= lo_q;
    end else if (cmd_i.up_wr) begin
      idx_q <= idx_q - {{(CW-1){1'b0}}, 1'b1};
    end else if (cmd_i.dn_wr) begin
      idx_q <= idx_p1;
    end
  end

  // Search window and refusal flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_q      <= '0;
      hi_q      <= '0;
      refused_q <= 1'b0;
    end else if (cmd_i.start) begin
      lo_q      <= '0;
      hi_q      <= count_q;
      refused_q <= 1'b0;
    end else begin
      if (cmd_i.srch_upd) begin
        if (entry_less) begin
          lo_q <= mid + {{(CW-1){1'b0}}, 1'b1};
        end else begin
          hi_q <= mid;
        end
      end
      if (cmd_i.set_refused) begin
        refused_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.put) begin
      count_q <= count_q + {{(CW-1){1'b0}}, 1'b1};
    end else if (cmd_i.cnt_dec) begin
      count_q <= count_q - {{(CW-1){1'b0}}, 1'b1};
    end
  end

  assign out_item_o = result_q;

endmodule

`default_nettype wire

// File: hw/rtl/sorted_integer_set_core.sv
// ----------------------------------------------------------------------------
// sorted_integer_set_core
// Set of distinct signed 32-bit integers kept in ascending order in a fixed
// store; each beat adds, removes or looks up one value and returns one result.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake              payload
//   -------  ---------  ---------------------  ---------------------------------
//   in       sink       in_valid_i/in_ready_o  in_item_i  {mode, value}
//   out      source     out_valid_o/out_ready_i out_item_o {was_present,
//                                                          refused_full, count}
//
// Steps of a beat, with n entries held and p the found position: accept,
//   binary search (one store read per step), check, shift and result, where
//   an insert moves n-p entries and a remove n-p-1, each with a read and a
//   write of the single-port store, whose read data is registered. One beat
//   is worked on at a time.
// Reset clears the entry count, window and state; the store is never cleared.
// A result waits in the output register while the next beat is taken in;
// a stalled output holds the sequencer only when its next result is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_integer_set_core #(
  parameter int unsigned CAPACITY = sis_pkg::CAPACITY_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire sis_pkg::in_item_t  in_item_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output sis_pkg::out_item_t      out_item_o
);

  sis_pkg::cmd_t  cmd;
  sis_pkg::stat_t stat;

  // Sequencer: search, check, shift and result hand-off.
  sis_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Store, window, index, count and result register.
  sis_dpath #(
    .CAPACITY(CAPACITY)
  ) u_dpath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_item_i (in_item_i),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .out_item_o(out_item_o)
  );

endmodule

`default_nettype wire

// File: hw/rtl/sis_checker.sv
// ----------------------------------------------------------------------------
// sis_checker
// Port-level checks of the sorted integer set, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sis_checker #(
  parameter int unsigned CAPACITY = sis_pkg::CAPACITY_DEF
) (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_o,
  input wire sis_pkg::in_item_t  in_item_i,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire sis_pkg::out_item_t out_item_o
);

  localparam logic SMALL_CAP = (CAPACITY < 128);

  // Hold a stalled result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed or dropped");

  // One beat in flight: drop ready right after an accept.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second beat taken while one is in flight");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_item_o.refused_full && out_item_o.was_present))
    else $error("refused add reported a present value");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && SMALL_CAP |-> out_item_o.count <= 7'(CAPACITY))
    else $error("count beyond capacity");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && SMALL_CAP && out_item_o.refused_full
      |-> out_item_o.count == 7'(CAPACITY))
    else $error("add refused while store not full");

endmodule

bind sorted_integer_set_core sis_checker #(
  .CAPACITY(CAPACITY)
) u_sis_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .in_item_i  (in_item_i),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_item_o (out_item_o)
);

`default_nettype wire

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench of sorted_integer_set_core. Every beat that the core accepts is
// also applied to a queue-based model of the sorted set. The model's result
// is stored, and each result beat that the core returns is checked against
// the oldest stored result, field by field. The run has directed edge
// values, a fill past capacity, random mixes, and an output hold-off. Random
// valid and ready gaps appear in the earlier tests, not in the last two.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SET_CAP = sis_pkg::CAPACITY_DEF;

  // The fourth mode code has no name in the package; the core treats it as a
  // lookup.
  localparam logic [1:0] MODE_SPARE = 2'd3;

  localparam int VAL_MIN = 32'sh8000_0000;
  localparam int VAL_MAX = 32'sh7fff_ffff;

  // The worst beat with a full store fits well within these loose margins.
  localparam int DRAIN_PAD       = 200;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int QUIET_LIMIT     = 4000;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  sis_pkg::in_item_t  in_item_i   = '0;
  logic               out_ready_i = 1'b0;
  logic               in_ready_o;
  logic               out_valid_o;
  sis_pkg::out_item_t out_item_o;

  // Set contents in ascending signed order, as the core should hold them.
  int                 held_values[$];
  // Results that were computed for accepted beats and not yet returned.
  sis_pkg::out_item_t pending_results[$];

  int        err_count     = 0;
  // Gate random gaps on both channels.
  bit        idle_on       = 1'b1;
  // Request a long ready hold-off of this many cycles; the sink clears it.
  int        hold_off_req  = 0;

  sorted_integer_set_core #(
    .CAPACITY(SET_CAP)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  initial begin : clock_gen
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Set model
  // --------------------------------------------------------------------------

  // Apply one beat to the held set and return the result that it must give.
  function automatic sis_pkg::out_item_t apply_set_op(sis_pkg::in_item_t beat);
    sis_pkg::out_item_t res;
    int        v;
    int        pos;
    bit        hit;
    v   = beat.value;
    pos = 0;
    // Find the first entry that is not below the value.
    while (pos < held_values.size() && held_values[pos] < v) pos++;
    hit = (pos < held_values.size()) && (held_values[pos] == v);
    res = '0;
    res.was_present = hit;
    case (beat.mode)
      sis_pkg::MODE_ADD: begin
        // Duplicates change nothing, even when the store is full.
        if (!hit) begin
          if (held_values.size() >= SET_CAP) res.refused_full = 1'b1;
          else held_values.insert(pos, v);
        end
      end
      sis_pkg::MODE_REMOVE: begin
        if (hit) held_values.delete(pos);
      end
      default: ;  // lookup, and the spare code acts as one
    endcase
    res.count = 7'(held_values.size());
    return res;
  endfunction

  // Prefer values that already sit in the set, and small values that collide
  // often. Keep some fully random values and some near the signed limits.
  function automatic int pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3:
        return (held_values.size() != 0) ?
               held_values[$urandom_range(0, held_values.size() - 1)] : $urandom;
      4, 5, 6:
        return $urandom_range(0, 40) - 20;
      7:
        return $urandom_range(0, 1) ? VAL_MIN + $urandom_range(0, 3)
                                    : VAL_MAX - $urandom_range(0, 3);
      default:
        return $urandom;
    endcase
  endfunction

  // bias: 0 shrinks the set, 1 keeps it level, 2 grows it.
  function automatic logic [1:0] pick_mode(int bias);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 4) return MODE_SPARE;
    if (roll < 20) return sis_pkg::MODE_QUERY;
    if (roll < 45 + 20 * bias) return sis_pkg::MODE_ADD;
    return sis_pkg::MODE_REMOVE;
  endfunction

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------

  // Offer one beat and hold it until it is accepted, then log its result.
  // Valid stays high on return, so a following send carries on back to back.
  // Callers that pause must go through drain_results, which drops valid.
  task automatic send_op(logic [1:0] mode, int value);
    sis_pkg::in_item_t beat;
    beat.mode  = mode;
    beat.value = value;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_item_i  <= beat;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(apply_set_op(beat));
  endtask

  // Drop valid and wait until every logged result is back, then let the core
  // settle.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_PAD) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Output side
  // --------------------------------------------------------------------------

  // Drive ready. Stall in random bursts while idling is on, and honor a long
  // hold-off request counted here.
  initial begin : result_sink
    int span;
    forever begin
      @(posedge clk_i);
      if (hold_off_req != 0) begin
        span         = hold_off_req;
        hold_off_req = 0;
        out_ready_i <= 1'b0;
        repeat (span) @(posedge clk_i);
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(0, 14)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Check each returned beat against the oldest logged result.
  always @(posedge clk_i) begin : result_check
    sis_pkg::out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing outstanding: %p", out_item_o);
        err_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_item_o.was_present !== want.was_present) begin
          $error("was_present: expected %0d, got %0d",
                 want.was_present, out_item_o.was_present);
          err_count++;
        end
        if (out_item_o.refused_full !== want.refused_full) begin
          $error("refused_full: expected %0d, got %0d",
                 want.refused_full, out_item_o.refused_full);
          err_count++;
        end
        if (out_item_o.count !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, out_item_o.count);
          err_count++;
        end
      end
    end
  end

  // End the run if neither channel moves a beat for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
        quiet = 0;
      else
        quiet++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Cover the signed limits, each mode, duplicates, and absent removes. End
  // with an empty set.
  task automatic test_edge_values();
    send_op(sis_pkg::MODE_QUERY,  VAL_MIN);          // lookup on an empty store
    send_op(sis_pkg::MODE_REMOVE, 0);                // absent remove on an empty store
    send_op(sis_pkg::MODE_ADD,    0);
    send_op(sis_pkg::MODE_ADD,    VAL_MAX);
    send_op(sis_pkg::MODE_ADD,    VAL_MIN);          // lands below every entry
    send_op(sis_pkg::MODE_ADD,    -1);
    send_op(sis_pkg::MODE_ADD,    1);
    send_op(sis_pkg::MODE_ADD,    0);                // duplicate add
    send_op(sis_pkg::MODE_QUERY,  VAL_MAX);
    send_op(sis_pkg::MODE_QUERY,  VAL_MAX - 1);      // absent neighbor of the top
    send_op(MODE_SPARE,           -1);               // spare code looks up only
    send_op(MODE_SPARE,           2);
    send_op(sis_pkg::MODE_REMOVE, 5);                // absent remove
    send_op(sis_pkg::MODE_REMOVE, 0);                // from the middle
    send_op(sis_pkg::MODE_REMOVE, VAL_MIN);          // from the bottom
    send_op(sis_pkg::MODE_REMOVE, VAL_MAX);          // from the top
    send_op(sis_pkg::MODE_ADD,    32'h5555_5555);
    send_op(sis_pkg::MODE_ADD,    32'haaaa_aaaa);
    send_op(sis_pkg::MODE_QUERY,  32'h5555_5555);
    send_op(sis_pkg::MODE_REMOVE, -1);
    send_op(sis_pkg::MODE_REMOVE, 1);
    send_op(sis_pkg::MODE_REMOVE, 32'h5555_5555);
    send_op(sis_pkg::MODE_REMOVE, 32'haaaa_aaaa);
    send_op(sis_pkg::MODE_REMOVE, -1);               // the set is empty again
    drain_results();
  endtask

  // Fill to capacity, with a bottom insert that shifts every entry. Push
  // refused adds and duplicates while full, then empty the set in random
  // order.
  task automatic test_full_store();
    idle_on = 1'b1;
    while (held_values.size() < SET_CAP - 1) begin
      if ($urandom_range(0, 7) == 0) send_op(sis_pkg::MODE_QUERY, pick_value());
      else send_op(sis_pkg::MODE_ADD, $urandom);
    end
    send_op(sis_pkg::MODE_ADD,
            (held_values[0] == VAL_MIN) ? VAL_MAX : held_values[0] - 1);
    while (held_values.size() < SET_CAP) send_op(sis_pkg::MODE_ADD, $urandom);
    repeat (4) send_op(sis_pkg::MODE_ADD, $urandom);  // new values into a full store
    send_op(sis_pkg::MODE_ADD, held_values[0]);       // duplicates stay accepted
    send_op(sis_pkg::MODE_ADD, held_values[$]);
    send_op(sis_pkg::MODE_QUERY, held_values[SET_CAP / 2]);
    send_op(MODE_SPARE, $urandom);
    send_op(sis_pkg::MODE_REMOVE, $urandom);
    send_op(sis_pkg::MODE_REMOVE, held_values[0]);    // close the gap across all entries
    send_op(sis_pkg::MODE_ADD, VAL_MIN);
    send_op(sis_pkg::MODE_ADD, $urandom);
    while (held_values.size() != 0) begin
      if ($urandom_range(0, 3) == 0)
        send_op($urandom_range(0, 1) ? sis_pkg::MODE_QUERY : sis_pkg::MODE_REMOVE,
                $urandom);
      else
        send_op(sis_pkg::MODE_REMOVE,
                held_values[$urandom_range(0, held_values.size() - 1)]);
    end
    drain_results();
  endtask

  // Run random chunks. Each chunk picks its own trend and its own idling, so
  // the set swings between empty and full.
  task automatic test_random_mix(int n_items);
    int bias;
    for (int chunk = 0; chunk < n_items / 50; chunk++) begin
      bias    = $urandom_range(0, 2);
      idle_on = ($urandom_range(0, 3) != 0);
      repeat (50) send_op(pick_mode(bias), pick_value());
    end
    drain_results();
  endtask

  // Hold ready low for a long stretch while the input keeps offering beats,
  // so the core backs up and drops in_ready_o.
  task automatic test_output_hold_off();
    idle_on      = 1'b0;
    hold_off_req = HOLD_OFF_CYCLES;
    repeat (30) send_op(pick_mode(1), pick_value());
    drain_results();
  endtask

  // Send the final stretch with no gaps on either side.
  task automatic test_back_to_back();
    idle_on = 1'b0;
    for (int chunk = 0; chunk < 5; chunk++) begin
      repeat (50) send_op(pick_mode(chunk % 3), pick_value());
    end
    drain_results();
  endtask

  initial begin : run
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_edge_values();
    test_full_store();
    test_random_mix(900);
    test_output_hold_off();
    test_back_to_back();
    if (err_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/sis_pkg.sv
hw/rtl/sis_ctrl.sv
hw/rtl/sis_dpath.sv
hw/rtl/sorted_integer_set_core.sv
hw/rtl/sis_checker.sv
verif/tb.sv
